/* sv/wsfr_pkg.sv */
`timescale 1ns / 1ps

package wsfr_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_FIN     = 3'd1;
  localparam logic [2:0] ERR_OPCODE  = 3'd2;
  localparam logic [2:0] ERR_LEN64   = 3'd3;
  localparam logic [2:0] ERR_TOOLONG = 3'd4;

  // Opcodes.
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;

  // Header byte positions that need special handling.
  localparam logic [2:0] HDR_FIRST    = 3'd0;
  localparam logic [2:0] HDR_LEN      = 3'd1;
  localparam logic [2:0] HDR_SHORT_END = 3'd5;
  localparam logic [2:0] HDR_EXT_END  = 3'd7;
  localparam logic [2:0] HDR_EXT_NEXT = 3'd6;

  // Length field codes.
  localparam logic [15:0] LEN_SHORT_MAX = 16'd125;
  localparam logic [15:0] LEN_EXT16     = 16'd126;

  // Reset value of the length limit register.
  localparam logic [15:0] MAX_LEN_RESET = 16'd2040;

  // Parser state carried from byte to byte.
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  header_count;
    logic [3:0]  frame_opcode;
    logic        fin_seen;
    logic [15:0] frame_length;
    logic [31:0] mask_key;
    logic [15:0] payload_count;
  } frame_state_t;

  // One result produced by a byte.
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        is_text;
    logic        last;
    logic [2:0]  error_code;
  } result_t;

endpackage

/* sv/wsfr_step.sv */
`timescale 1ns / 1ps

module wsfr_step (
  input  wsfr_pkg::frame_state_t cur,
  input  logic [7:0]             rx_byte,
  input  logic [15:0]            max_payload_len,
  output wsfr_pkg::frame_state_t next,
  output wsfr_pkg::result_t      res
);

  logic [7:0]  key_byte;
  logic [15:0] count_inc;
  logic        payload_last;
  logic        text_frame;
  logic        op_valid;
  logic [31:0] key_shifted;
  logic        len_zero;

  // Key byte for the current payload position; the first key byte sits at the top.
  always_comb begin
    case (cur.payload_count[1:0])
      2'd0:    key_byte = cur.mask_key[31:24];
      2'd1:    key_byte = cur.mask_key[23:16];
      2'd2:    key_byte = cur.mask_key[15:8];
      default: key_byte = cur.mask_key[7:0];
    endcase
  end

  // Shared conditions.
  assign count_inc    = cur.payload_count + 16'd1;
  assign payload_last = (count_inc == cur.frame_length);
  assign text_frame   = (cur.frame_opcode == wsfr_pkg::OP_TEXT);
  assign op_valid     = text_frame || (cur.frame_opcode == wsfr_pkg::OP_BINARY);
  assign key_shifted  = {cur.mask_key[23:0], rx_byte};
  assign len_zero     = (cur.frame_length == 16'd0);

  // Next state.
  always_comb begin
    next = cur;
    case (cur.phase)
      wsfr_pkg::PH_PAYLOAD: begin
        if (payload_last) begin
          next.phase         = wsfr_pkg::PH_HEADER;
          next.header_count  = wsfr_pkg::HDR_FIRST;
          next.payload_count = 16'd0;
        end else begin
          next.payload_count = count_inc;
        end
      end
      wsfr_pkg::PH_HEADER: begin
        case (cur.header_count)
          wsfr_pkg::HDR_FIRST: begin
            next.fin_seen     = rx_byte[7];
            next.frame_opcode = rx_byte[3:0];
            next.header_count = wsfr_pkg::HDR_LEN;
          end
          wsfr_pkg::HDR_LEN: begin
            next.frame_length = {9'd0, rx_byte[6:0]};
            next.header_count = cur.header_count + 3'd1;
          end
          wsfr_pkg::HDR_SHORT_END: begin
            next.mask_key = key_shifted;
            if (!cur.fin_seen || !op_valid) begin
              // Missing FIN, close frame and bad opcode all stop the parser.
              next.phase = wsfr_pkg::PH_HALTED;
            end else if (cur.frame_length <= wsfr_pkg::LEN_SHORT_MAX) begin
              next.header_count  = wsfr_pkg::HDR_FIRST;
              next.payload_count = 16'd0;
              next.phase = len_zero ? wsfr_pkg::PH_HEADER : wsfr_pkg::PH_PAYLOAD;
            end else if (cur.frame_length == wsfr_pkg::LEN_EXT16) begin
              next.frame_length = key_shifted[31:16];
              next.header_count = wsfr_pkg::HDR_EXT_NEXT;
            end else begin
              next.phase = wsfr_pkg::PH_HALTED;
            end
          end
          wsfr_pkg::HDR_EXT_END: begin
            next.mask_key = key_shifted;
            if (cur.frame_length > max_payload_len) begin
              next.phase = wsfr_pkg::PH_HALTED;
            end else begin
              next.header_count  = wsfr_pkg::HDR_FIRST;
              next.payload_count = 16'd0;
              next.phase = len_zero ? wsfr_pkg::PH_HEADER : wsfr_pkg::PH_PAYLOAD;
            end
          end
          default: begin
            next.mask_key     = key_shifted;
            next.header_count = cur.header_count + 3'd1;
          end
        endcase
      end
      default: begin
        next = cur;
      end
    endcase
  end

  // Result for this byte.
  always_comb begin
    res = '0;
    case (cur.phase)
      wsfr_pkg::PH_PAYLOAD: begin
        res.valid   = 1'b1;
        res.kind    = wsfr_pkg::KIND_DATA;
        res.data    = rx_byte ^ key_byte;
        res.is_text = text_frame;
        res.last    = payload_last;
      end
      wsfr_pkg::PH_HEADER: begin
        if (cur.header_count == wsfr_pkg::HDR_SHORT_END) begin
          res.valid = 1'b1;
          if (!cur.fin_seen) begin
            res.kind       = wsfr_pkg::KIND_ERROR;
            res.error_code = wsfr_pkg::ERR_FIN;
          end else if (cur.frame_opcode == wsfr_pkg::OP_CLOSE) begin
            res.kind = wsfr_pkg::KIND_CLOSE;
          end else if (!op_valid) begin
            res.kind       = wsfr_pkg::KIND_ERROR;
            res.error_code = wsfr_pkg::ERR_OPCODE;
          end else if (cur.frame_length <= wsfr_pkg::LEN_SHORT_MAX) begin
            res.valid   = len_zero;
            res.kind    = wsfr_pkg::KIND_EMPTY;
            res.is_text = text_frame;
          end else if (cur.frame_length == wsfr_pkg::LEN_EXT16) begin
            res.valid = 1'b0;
          end else begin
            res.kind       = wsfr_pkg::KIND_ERROR;
            res.error_code = wsfr_pkg::ERR_LEN64;
          end
        end else if (cur.header_count == wsfr_pkg::HDR_EXT_END) begin
          if (cur.frame_length > max_payload_len) begin
            res.valid      = 1'b1;
            res.kind       = wsfr_pkg::KIND_ERROR;
            res.error_code = wsfr_pkg::ERR_TOOLONG;
          end else begin
            res.valid   = len_zero;
            res.kind    = wsfr_pkg::KIND_EMPTY;
            res.is_text = text_frame;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

/* sv/websocket_frame_receiver.sv */
`timescale 1ns / 1ps
// The result of a byte is registered at the clock edge that accepts the byte.
// Throughput: one byte per cycle; the result register stalls the input only while it is full
// and the downstream side is stalling.
// Reset (synchronous, active high) returns the parser to the start of a header, empties the
// result register and sets max_payload_len to 2040.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  data,
  output logic        is_text,
  output logic        last,
  output logic [2:0]  error_code
);

  wsfr_pkg::frame_state_t state;
  wsfr_pkg::frame_state_t state_next;
  wsfr_pkg::result_t      res;
  logic [15:0]            max_payload_len;
  logic                   in_accept;
  logic                   out_free;

  // The result register can take a new transaction when empty or being drained.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !out_free;
  assign in_accept = in_valid && out_free;

  // Byte parser.
  wsfr_step u_step (
    .cur             (state),
    .rx_byte         (rx_byte),
    .max_payload_len (max_payload_len),
    .next            (state_next),
    .res             (res)
  );

  // Length limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= wsfr_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_payload_len <= cfg_wr_data;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: wsfr_pkg::PH_HEADER, default: '0};
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && in_accept && res.valid) begin
      kind       <= res.kind;
      data       <= res.data;
      is_text    <= res.is_text;
      last       <= res.last;
      error_code <= res.error_code;
    end
  end

endmodule

/* sv/wsfr_checker.sv */
`timescale 1ns / 1ps

module wsfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [7:0]  data,
  input logic        is_text,
  input logic        last,
  input logic [2:0]  error_code
);

  // A stalled result holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data)
      && $stable(last) && $stable(error_code))
    else $error("stalled result changed");

  // The input is only held back by a full, stalled result register.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // Only payload results carry data or a last flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != wsfr_pkg::KIND_DATA |-> data == 8'd0 && !last)
    else $error("non-payload result carries data");

  // Error codes appear exactly on error results; close and error carry no text flag.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == wsfr_pkg::KIND_ERROR) == (error_code != wsfr_pkg::ERR_NONE))
      && (error_code <= wsfr_pkg::ERR_TOOLONG)
      && !((kind == wsfr_pkg::KIND_ERROR || kind == wsfr_pkg::KIND_CLOSE) && is_text))
    else $error("inconsistent result fields");

  // Once a close or error transaction is taken the receiver goes quiet.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall
      && (kind == wsfr_pkg::KIND_CLOSE || kind == wsfr_pkg::KIND_ERROR) |=> !out_valid)
    else $error("result after close or error");

endmodule

bind websocket_frame_receiver wsfr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .kind       (kind),
  .data       (data),
  .is_text    (is_text),
  .last       (last),
  .error_code (error_code)
);

/* dv/ws_frame_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the frame receiver. Every byte transaction that is
// accepted is run through a local copy of the parser, and each result
// transaction is compared with the oldest prediction still waiting.
module ws_frame_checker
  import wsfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  data,
  input  logic        is_text,
  input  logic        last,
  input  logic [2:0]  error_code,
  output int          mismatch_count,
  output int          pending_count
);

  // One result transaction as it should appear on the output port.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       is_text;
    logic       last;
    logic [2:0] error_code;
  } frame_event_t;

  // Local parser state and the shadow of the length limit register.
  phase_t      parse_phase;
  logic [2:0]  hdr_pos;
  logic [3:0]  frame_op;
  logic        fin_bit;
  logic [15:0] frame_len;
  logic [31:0] key_word;
  logic [15:0] byte_pos;
  logic [15:0] length_limit;

  frame_event_t expected_events[$];

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // A protocol violation ends parsing until the next reset.
  function automatic bit halt_on(input logic [2:0] code, output frame_event_t ev);
    ev = '0;
    parse_phase = PH_HALTED;
    ev.kind = KIND_ERROR;
    ev.error_code = code;
    return 1'b1;
  endfunction

  // The header is good: an empty frame completes at once, otherwise the
  // payload follows.
  function automatic bit finish_header(output frame_event_t ev);
    ev = '0;
    hdr_pos = HDR_FIRST;
    byte_pos = '0;
    if (frame_len == '0) begin
      parse_phase = PH_HEADER;
      ev.kind = KIND_EMPTY;
      ev.is_text = (frame_op == OP_TEXT);
      return 1'b1;
    end
    parse_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Advances the parser by one received byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] b, output frame_event_t ev);
    logic [1:0] lane;
    ev = '0;
    if (parse_phase == PH_PAYLOAD) begin
      lane = byte_pos[1:0];
      byte_pos = byte_pos + 16'd1;
      ev.kind = KIND_DATA;
      ev.data = b ^ key_word[31 - 8 * lane -: 8];
      ev.is_text = (frame_op == OP_TEXT);
      ev.last = (byte_pos == frame_len);
      if (ev.last) begin
        parse_phase = PH_HEADER;
        hdr_pos = HDR_FIRST;
        byte_pos = '0;
      end
      return 1'b1;
    end
    if (parse_phase != PH_HEADER) begin
      return 1'b0;
    end
    if (hdr_pos == HDR_FIRST) begin
      fin_bit = b[7];
      frame_op = b[3:0];
      hdr_pos = HDR_LEN;
      return 1'b0;
    end
    if (hdr_pos == HDR_LEN) begin
      frame_len = {9'd0, b[6:0]};
      hdr_pos = hdr_pos + 3'd1;
      return 1'b0;
    end

    // Remaining header bytes shift through the key word, extended length first.
    key_word = {key_word[23:0], b};
    if (hdr_pos == HDR_SHORT_END) begin
      if (!fin_bit) begin
        return halt_on(ERR_FIN, ev);
      end
      if (frame_op == OP_CLOSE) begin
        parse_phase = PH_HALTED;
        ev.kind = KIND_CLOSE;
        return 1'b1;
      end
      if (frame_op != OP_TEXT && frame_op != OP_BINARY) begin
        return halt_on(ERR_OPCODE, ev);
      end
      if (frame_len <= LEN_SHORT_MAX) begin
        return finish_header(ev);
      end
      if (frame_len == LEN_EXT16) begin
        frame_len = key_word[31:16];
        hdr_pos = HDR_EXT_NEXT;
        return 1'b0;
      end
      return halt_on(ERR_LEN64, ev);
    end
    if (hdr_pos == HDR_EXT_END) begin
      if (frame_len > length_limit) begin
        return halt_on(ERR_TOOLONG, ev);
      end
      return finish_header(ev);
    end
    hdr_pos = hdr_pos + 3'd1;
    return 1'b0;
  endfunction

  // Both channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    frame_event_t got;
    frame_event_t want;
    frame_event_t fresh;
    if (rst) begin
      parse_phase = PH_HEADER;
      hdr_pos = HDR_FIRST;
      frame_op = '0;
      fin_bit = 1'b0;
      frame_len = '0;
      key_word = '0;
      byte_pos = '0;
      length_limit = MAX_LEN_RESET;
      expected_events.delete();
    end else begin
      // Result transaction: compare field by field with the oldest prediction.
      if (out_valid && !out_stall) begin
        got = {kind, data, is_text, last, error_code};
        if (expected_events.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: kind %0d data %02h",
                                    got.kind, got.data));
        end else begin
          want = expected_events.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
          if (got.data !== want.data)
            report_mismatch($sformatf("data %02h, expected %02h", got.data, want.data));
          if (got.is_text !== want.is_text)
            report_mismatch($sformatf("is_text %0b, expected %0b", got.is_text, want.is_text));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
          if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code %0d, expected %0d",
                                      got.error_code, want.error_code));
        end
      end

      // Byte transaction: predict whatever result it causes.
      if (in_valid && !in_stall) begin
        if (deframe_byte(rx_byte, fresh)) begin
          expected_events.push_back(fresh);
        end
      end

      // A limit written at this edge only applies to later bytes.
      if (cfg_wr_en) begin
        length_limit = cfg_wr_data;
      end
    end
    pending_count = expected_events.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import wsfr_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int BYTES_PER_PHASE = 130;

  // Halting frame that closes the run; only one can occur since the block
  // stays halted until reset.
  typedef enum int {
    END_FIN_CLEAR,
    END_CLOSE,
    END_BAD_OPCODE,
    END_LEN64,
    END_TOO_LONG
  } ending_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data;
  logic        is_text;
  logic        last;
  logic [2:0]  error_code;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int bytes_taken = 0;
  bit no_gaps = 1'b0;

  websocket_frame_receiver dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .data        (data),
    .is_text     (is_text),
    .last        (last),
    .error_code  (error_code)
  );

  ws_frame_checker frame_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .data           (data),
    .is_text        (is_text),
    .last           (last),
    .error_code     (error_code),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Downstream stalls: long and short free stretches, short stalls and the odd long one.
  initial begin
    int pick;
    int span;
    logic stall_on;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        stall_on = 1'b0;
        span = $urandom_range(20, 120);
      end else if (pick < 70) begin
        stall_on = 1'b0;
        span = $urandom_range(1, 4);
      end else if (pick < 95) begin
        stall_on = 1'b1;
        span = $urandom_range(1, 3);
      end else begin
        stall_on = 1'b1;
        span = $urandom_range(10, 40);
      end
      repeat (span) begin
        @(negedge clk);
        out_stall <= stall_on;
      end
    end
  end

  // Idle cycles before a byte: mostly none, sometimes a few, rarely many.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one byte and holds it until the transaction is accepted.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_taken++;
  endtask

  // Stops sending, waits for every predicted result and lets the block settle.
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One frame: header with random reserved and mask bits, then the payload.
  task automatic send_frame(input bit fin, input logic [3:0] op, input logic [6:0] len7,
                            input logic [15:0] ext_len, input logic [31:0] key,
                            input int payload_len);
    no_gaps = ($urandom_range(0, 3) == 0);
    put_byte({fin, 3'($urandom_range(0, 7)), op});
    put_byte({1'($urandom_range(0, 1)), len7});
    if (len7 == LEN_EXT16[6:0]) begin
      put_byte(ext_len[15:8]);
      put_byte(ext_len[7:0]);
    end
    for (int i = 3; i >= 0; i--) begin
      put_byte(key[8 * i +: 8]);
    end
    repeat (payload_len) put_byte(8'($urandom));
  endtask

  // A well-formed text or binary frame, mostly short, that the limit accepts.
  task automatic random_frame(input logic [15:0] limit);
    int pick;
    int count;
    logic [15:0] cap;
    logic [3:0] op;
    logic [6:0] len7;
    logic [15:0] ext_len;
    op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    pick = $urandom_range(0, 99);
    ext_len = '0;
    if (pick < 10) len7 = 7'd0;
    else if (pick < 45) len7 = 7'($urandom_range(1, 8));
    else if (pick < 70) len7 = 7'($urandom_range(9, 40));
    else if (pick < 80) len7 = 7'($urandom_range(41, 124));
    else if (pick < 85) len7 = LEN_SHORT_MAX[6:0];
    else begin
      len7 = LEN_EXT16[6:0];
      cap = (limit < 16'd300) ? limit : 16'd300;
      ext_len = 16'($urandom_range(0, (pick < 95 && cap > 40) ? 40 : cap));
    end
    count = (len7 == LEN_EXT16[6:0]) ? int'(ext_len) : int'(len7);
    send_frame(1'b1, op, len7, ext_len, $urandom, count);
  endtask

  initial begin
    logic [15:0] limit_plan [6];
    logic [15:0] limit;
    logic [3:0] op;
    int phase_start;
    ending_t ending;

    // Synchronous reset, held from time zero and released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset limit: empty short text, empty extended
    // binary and a short text frame with an uneven key.
    send_frame(1'b1, OP_TEXT, 7'd0, 16'd0, 32'h0000_0000, 0);
    send_frame(1'b1, OP_BINARY, LEN_EXT16[6:0], 16'd0, 32'hFFFF_FFFF, 0);
    send_frame(1'b1, OP_TEXT, 7'd5, 16'd0, 32'hFF00_A55A, 5);

    // Random frames under a range of limits, the extremes among them.
    limit_plan[0] = 16'd0;
    limit_plan[1] = 16'hFFFF;
    limit_plan[2] = LEN_EXT16;
    limit_plan[3] = 16'($urandom_range(127, 300));
    limit_plan[4] = 16'($urandom_range(0, 65535));
    limit_plan[5] = LEN_SHORT_MAX;
    for (int p = 0; p < 6; p++) begin
      limit = limit_plan[p];
      drain_and_settle();
      write_limit(limit);
      phase_start = bytes_taken;
      // An extended frame exactly at the limit where that stays affordable.
      if (limit <= 16'd300) begin
        send_frame(1'b1, OP_BINARY, LEN_EXT16[6:0], limit, $urandom, int'(limit));
      end
      while (bytes_taken - phase_start < BYTES_PER_PHASE) begin
        random_frame(limit);
      end
    end

    // One halting frame, then bytes that must be ignored.
    drain_and_settle();
    ending = ending_t'($urandom_range(0, 4));
    case (ending)
      END_FIN_CLEAR: begin
        send_frame(1'b0, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                   16'($urandom), $urandom, 0);
      end
      END_CLOSE: begin
        send_frame(1'b1, OP_CLOSE, 7'($urandom_range(0, 127)), 16'($urandom), $urandom, 0);
      end
      END_BAD_OPCODE: begin
        do op = 4'($urandom_range(0, 15));
        while (op == OP_TEXT || op == OP_BINARY || op == OP_CLOSE);
        send_frame(1'b1, op, 7'($urandom_range(0, 127)), 16'($urandom), $urandom, 0);
      end
      END_LEN64: begin
        send_frame(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, 7'd127, 16'd0,
                   $urandom, 0);
      end
      default: begin
        limit = 16'($urandom_range(0, 65534));
        write_limit(limit);
        send_frame(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, LEN_EXT16[6:0],
                   16'($urandom_range(int'(limit) + 1, 65535)), $urandom, 0);
      end
    endcase
    repeat ($urandom_range(10, 40)) put_byte(8'($urandom));

    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/wsfr_pkg.sv
sv/wsfr_step.sv
sv/websocket_frame_receiver.sv
sv/wsfr_checker.sv
dv/ws_frame_checker.sv
dv/tb_top.sv
